FILE: rtl/lrpd_pkg.sv
// ---------------------------------------------------------------------------
// lrpd_pkg - shared types and constants for the latching relay pulse driver
// Command codes, relay position and sequence phase codes, port bytes and the
// item structs passed between the pipeline stages.
// ---------------------------------------------------------------------------
`default_nettype none

package lrpd_pkg;

  // Port bytes
  localparam logic [7:0] PORT_POL_A = 8'hC0;
  localparam logic [7:0] PORT_POL_B = 8'h30;
  localparam logic [7:0] PORT_OFF   = 8'h50;

  // Coil time after reset
  localparam logic [15:0] COIL_RESET = 16'd20;

  // Register map
  localparam int          CFG_ADDR_W    = 3;
  localparam logic        REG_COIL_TICKS = 1'b0;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_TOGGLE = 2'd2,
    FUNC_PULSE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    POS_UNKNOWN = 2'd0,
    POS_OFF     = 2'd1,
    POS_ON      = 2'd2
  } pos_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_OFF       = 2'd1,
    PH_PULSE_OFF = 2'd2,
    PH_REVERSE   = 2'd3
  } phase_t;

  // One command item
  typedef struct packed {
    func_t       func;
    logic        level;
    logic [31:0] pulse_ticks;
  } item_t;

  // One result item
  typedef struct packed {
    logic       port_write;
    logic [7:0] port_value;
    logic [1:0] position;
    logic       toggle_ok;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lrpd_apb.sv
// ---------------------------------------------------------------------------
// lrpd_apb - configuration register port
// Holds the coil time register behind an APB-style slave with no wait states.
// ---------------------------------------------------------------------------
`default_nettype none

module lrpd_apb (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [15:0]                     coil_ticks
);
  import lrpd_pkg::*;

  logic reg_sel;

  // Word index sits above the byte offset
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_COIL_TICKS);
  assign pready  = 1'b1;

  // Coil time register
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_ticks <= COIL_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      coil_ticks <= pwdata[15:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {16'd0, coil_ticks};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrpd_in_stage.sv
// ---------------------------------------------------------------------------
// lrpd_in_stage - input register
// Captures one command item and hands it to the sequencer; refills in the
// same cycle that the held item moves on.
// ---------------------------------------------------------------------------
`default_nettype none

module lrpd_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lrpd_pkg::item_t in_item,
  input  wire logic            advance,
  output logic                 held_valid,
  output lrpd_pkg::item_t      held_item
);
  import lrpd_pkg::*;

  assign in_ready = !held_valid || advance;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrpd_seq.sv
// ---------------------------------------------------------------------------
// lrpd_seq - relay sequencer
// Keeps relay position, phase, tick countdown and pulse wait, and works out
// the result of one item in a single pass; state moves on when fire is high.
// ---------------------------------------------------------------------------
`default_nettype none

module lrpd_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire lrpd_pkg::item_t item,
  input  wire logic [15:0]     coil_ticks,
  output lrpd_pkg::result_t    result
);
  import lrpd_pkg::*;

  pos_t        relay_position, relay_position_next;
  phase_t      phase, phase_next;
  logic [31:0] countdown, countdown_next;
  logic [31:0] pulse_hold, pulse_hold_next;

  logic [31:0] coil_time;
  logic [31:0] count_dec;
  logic        pos_known;

  assign coil_time = (coil_ticks == 16'd0) ? 32'd1 : {16'd0, coil_ticks};
  assign count_dec = countdown - 32'd1;
  assign pos_known = (relay_position == POS_OFF) || (relay_position == POS_ON);

  // Step logic
  always_comb begin
    relay_position_next = relay_position;
    phase_next          = phase;
    countdown_next      = countdown;
    pulse_hold_next     = pulse_hold;
    result              = '0;
    unique case (item.func)
      FUNC_SET: begin
        result.port_write   = 1'b1;
        result.port_value   = item.level ? PORT_POL_A : PORT_POL_B;
        relay_position_next = item.level ? POS_ON : POS_OFF;
        phase_next          = PH_OFF;
        countdown_next      = coil_time;
      end
      FUNC_TOGGLE: begin
        if (pos_known) begin
          result.port_write   = 1'b1;
          result.toggle_ok    = 1'b1;
          result.port_value   = (relay_position == POS_OFF) ? PORT_POL_A : PORT_POL_B;
          relay_position_next = (relay_position == POS_OFF) ? POS_ON : POS_OFF;
          phase_next          = PH_OFF;
          countdown_next      = coil_time;
        end
      end
      FUNC_PULSE: begin
        pulse_hold_next     = item.pulse_ticks;
        result.port_write   = 1'b1;
        result.port_value   = PORT_POL_A;
        relay_position_next = POS_ON;
        phase_next          = PH_PULSE_OFF;
        countdown_next      = coil_time;
      end
      FUNC_TICK: begin
        if (phase != PH_IDLE && countdown != 32'd0) begin
          countdown_next = count_dec;
          // Pending action falls due
          if (count_dec == 32'd0) begin
            unique case (phase)
              PH_OFF: begin
                result.port_write = 1'b1;
                result.port_value = PORT_OFF;
                phase_next        = PH_IDLE;
              end
              PH_PULSE_OFF: begin
                result.port_write = 1'b1;
                result.port_value = PORT_OFF;
                phase_next        = PH_REVERSE;
                countdown_next    = (pulse_hold == 32'd0) ? 32'd1 : pulse_hold;
              end
              default: begin
                if (pos_known) begin
                  result.port_write   = 1'b1;
                  result.port_value   = (relay_position == POS_OFF) ? PORT_POL_A
                                                                    : PORT_POL_B;
                  relay_position_next = (relay_position == POS_OFF) ? POS_ON : POS_OFF;
                  phase_next          = PH_OFF;
                  countdown_next      = coil_time;
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            endcase
          end
        end else begin
          phase_next     = PH_IDLE;
          countdown_next = 32'd0;
        end
      end
    endcase
    result.position = relay_position_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_position <= POS_UNKNOWN;
      phase          <= PH_IDLE;
      countdown      <= 32'd0;
      pulse_hold     <= 32'd0;
    end else if (fire) begin
      relay_position <= relay_position_next;
      phase          <= phase_next;
      countdown      <= countdown_next;
      pulse_hold     <= pulse_hold_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/latching_relay_pulse_driver.sv
// ---------------------------------------------------------------------------
// latching_relay_pulse_driver - bistable relay coil driver
// Top level: config port, input register, sequencer and result register.
// ---------------------------------------------------------------------------
// Every command item (tick, set, toggle, pulse) gives exactly one result item.
// Each accepted item is held in the input register; when it moves on, the
// sequencer's one-pass result is written into the result register and is
// valid there. A new item is taken every cycle as long as results are
// drained; the state update of one item is in place before the next item
// is worked on, so the throughput is one item per clock.
// Coil and pulse timing count tick items, not clocks.
// Write coil_ticks only while no items are in flight.
`default_nettype none

module latching_relay_pulse_driver (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  // Command items
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      func,
  input  wire logic                            level,
  input  wire logic [31:0]                     pulse_ticks,
  // Result items
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 port_write,
  output logic      [7:0]                      port_value,
  output logic      [1:0]                      position,
  output logic                                 toggle_ok
);
  import lrpd_pkg::*;

  logic [15:0] coil_ticks;
  item_t       in_item;
  item_t       held_item;
  logic        held_valid;
  logic        advance;
  result_t     step_result;
  result_t     out_result;

  lrpd_apb u_apb (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .coil_ticks (coil_ticks)
  );

  assign in_item.func        = func_t'(func);
  assign in_item.level       = level;
  assign in_item.pulse_ticks = pulse_ticks;

  lrpd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Held item moves on when the result register is free or draining
  assign advance = held_valid && (!out_valid || out_ready);

  lrpd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (held_item),
    .coil_ticks (coil_ticks),
    .result     (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign port_write = out_result.port_write;
  assign port_value = out_result.port_value;
  assign position   = out_result.position;
  assign toggle_ok  = out_result.toggle_ok;

  // Checks
  a_no_write_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !port_write |-> port_value == 8'h00)
    else $error("port value set without a port write");

  a_toggle_drives : assert property (@(posedge clk) disable iff (rst)
    out_valid && toggle_ok |->
      port_write && (port_value == PORT_POL_A || port_value == PORT_POL_B))
    else $error("successful toggle without a coil drive");

  a_set_writes : assert property (@(posedge clk) disable iff (rst)
    advance && held_item.func == FUNC_SET |=> out_valid && port_write)
    else $error("set item gave no port write");

endmodule

`default_nettype wire

FILE: verif/tb_latching_relay_pulse_driver.sv
// ---------------------------------------------------------------------------
// tb_latching_relay_pulse_driver - testbench for the latching relay driver
// Drives command items and coil_ticks writes into the block. A predictor of
// the relay position, coil sequence and tick countdown works out the result
// item for every accepted command. A checker process compares each result
// field by field. Both handshake sides idle at random, and one phase holds
// the result side off long enough for the block to stall its input.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_latching_relay_pulse_driver;
  import lrpd_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 6;

  // Byte addresses: index 0 is coil_ticks, index 1 has no register behind it
  localparam logic [CFG_ADDR_W-1:0] ADDR_COIL     = CFG_ADDR_W'(4 * REG_COIL_TICKS);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = CFG_ADDR_W'(4);

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd_func  = FUNC_TICK;
  logic        cmd_level = 1'b0;
  logic [31:0] cmd_ticks = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        port_write;
  logic [7:0]  port_value;
  logic [1:0]  position;
  logic        toggle_ok;

  // Predicted relay state and coil time
  pos_t        rel_pos;
  phase_t      seq_phase;
  logic [31:0] tick_left;
  logic [31:0] hold_len;
  logic [15:0] coil_len;

  result_t     relay_results[$];
  int          err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  bit          no_idle      = 1'b0;
  bit          hold_off_req = 1'b0;

  latching_relay_pulse_driver DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (cmd_func),
    .level      (cmd_level),
    .pulse_ticks(cmd_ticks),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .port_write (port_write),
    .port_value (port_value),
    .position   (position),
    .toggle_ok  (toggle_ok)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [31:0] coil_time();
    return (coil_len == 16'd0) ? 32'd1 : {16'd0, coil_len};
  endfunction

  // Energise the coil towards a position and arm the coil-off
  function automatic logic [7:0] energise(input bit on);
    rel_pos   = on ? POS_ON : POS_OFF;
    seq_phase = PH_OFF;
    tick_left = coil_time();
    return on ? PORT_POL_A : PORT_POL_B;
  endfunction

  function automatic result_t relay_step(input func_t f, input logic lvl,
                                         input logic [31:0] pt);
    result_t r;
    r = '0;
    case (f)
      FUNC_SET: begin
        r.port_value = energise(lvl);
        r.port_write = 1'b1;
      end
      FUNC_TOGGLE: begin
        if (rel_pos == POS_OFF || rel_pos == POS_ON) begin
          r.port_value = energise(rel_pos == POS_OFF);
          r.port_write = 1'b1;
          r.toggle_ok  = 1'b1;
        end
      end
      FUNC_PULSE: begin
        hold_len     = pt;
        r.port_value = energise(1'b1);
        r.port_write = 1'b1;
        seq_phase    = PH_PULSE_OFF;
      end
      default: begin
        if (seq_phase != PH_IDLE && tick_left != 32'd0) begin
          tick_left = tick_left - 32'd1;
          if (tick_left == 32'd0) begin
            if (seq_phase == PH_OFF) begin
              r.port_value = PORT_OFF;
              r.port_write = 1'b1;
              seq_phase    = PH_IDLE;
            end else if (seq_phase == PH_PULSE_OFF) begin
              r.port_value = PORT_OFF;
              r.port_write = 1'b1;
              seq_phase    = PH_REVERSE;
              tick_left    = (hold_len == 32'd0) ? 32'd1 : hold_len;
            end else if (rel_pos == POS_OFF || rel_pos == POS_ON) begin
              r.port_value = energise(rel_pos == POS_OFF);
              r.port_write = 1'b1;
            end else begin
              seq_phase = PH_IDLE;
            end
          end
        end else begin
          seq_phase = PH_IDLE;
          tick_left = 32'd0;
        end
      end
    endcase
    r.position = rel_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Gap lengths: mostly short, a few long
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int rx_left;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_off_req = 1'b0;
        rx_left      = 0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        rx_left    = 0;
      end else if (rx_left > 0) begin
        rx_left--;
      end else if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        rx_left    = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b0;
        rx_left    = gap_len() - 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (relay_results.size() == 0) begin
        $error("result item with no expectation waiting");
        err_cnt++;
      end else begin
        exp_r = relay_results.pop_front();
        if (port_write !== exp_r.port_write) begin
          $error("port_write: expected %0d, got %0d", exp_r.port_write, port_write);
          err_cnt++;
        end
        if (port_value !== exp_r.port_value) begin
          $error("port_value: expected 0x%02h, got 0x%02h", exp_r.port_value, port_value);
          err_cnt++;
        end
        if (position !== exp_r.position) begin
          $error("position: expected %0d, got %0d", exp_r.position, position);
          err_cnt++;
        end
        if (toggle_ok !== exp_r.toggle_ok) begin
          $error("toggle_ok: expected %0d, got %0d", exp_r.toggle_ok, toggle_ok);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------
  // Offer one command item, wait for it to be taken, then maybe idle
  task automatic send_cmd(input func_t f, input logic lvl, input logic [31:0] pt);
    int gap;
    in_valid  <= 1'b1;
    cmd_func  <= f;
    cmd_level <= lvl;
    cmd_ticks <= pt;
    do @(posedge clk); while (!in_ready);
    relay_results.push_back(relay_step(f, lvl, pt));
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 35) gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result is in and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (relay_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_COIL) coil_len = data[15:0];
  endtask

  task automatic set_coil(input logic [15:0] ticks);
    drain();
    cfg_write(ADDR_COIL, {16'($urandom), ticks});
  endtask

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------
  // Tick while idle, toggle with unknown position
  task automatic test_after_reset();
    send_cmd(FUNC_TICK, 1'b1, 32'hFFFF_FFFF);
    send_cmd(FUNC_TOGGLE, 1'b0, 32'd0);
  endtask

  // Set on, then two successful toggles, all with the reset coil time
  task automatic test_set_toggle();
    send_cmd(FUNC_SET, 1'b1, 32'd0);
    send_cmd(FUNC_TOGGLE, 1'b1, 32'd7);
    send_cmd(FUNC_TOGGLE, 1'b0, 32'd0);
  endtask

  // Coil time of zero behaves as one tick
  task automatic test_zero_coil();
    set_coil(16'd0);
    send_cmd(FUNC_SET, 1'b0, 32'd0);
    send_cmd(FUNC_TICK, 1'b0, 32'd0);
    send_cmd(FUNC_TICK, 1'b0, 32'd0);
  endtask

  // Full pulse with a zero wait, then a set replacing a long pulse
  task automatic test_pulse();
    set_coil(16'd2);
    send_cmd(FUNC_PULSE, 1'b0, 32'd0);
    repeat (6) send_cmd(FUNC_TICK, 1'b0, 32'd0);
    send_cmd(FUNC_PULSE, 1'b1, 32'hFFFF_FFFF);
    send_cmd(FUNC_TICK, 1'b0, 32'd0);
    send_cmd(FUNC_SET, 1'b0, 32'h5A5A_A5A5);
  endtask

  // Write to an index with no register: the coil time must not change
  task automatic test_unmapped_register();
    drain();
    cfg_write(ADDR_UNMAPPED, 32'd1);
    send_cmd(FUNC_SET, 1'b1, 32'd0);
    send_cmd(FUNC_TICK, 1'b0, 32'd0);
    send_cmd(FUNC_TICK, 1'b0, 32'd0);
  endtask

  // Longest coil time
  task automatic test_max_coil();
    set_coil(16'hFFFF);
    send_cmd(FUNC_SET, 1'b0, 32'd0);
    send_cmd(FUNC_TICK, 1'b1, 32'd0);
  endtask

  // ---------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------
  task automatic random_cmds(input int n);
    int    r;
    func_t f;
    logic [31:0] pt;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 50)      f = FUNC_TICK;
      else if (r < 68) f = FUNC_SET;
      else if (r < 84) f = FUNC_TOGGLE;
      else             f = FUNC_PULSE;
      pt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5);
      send_cmd(f, 1'($urandom), pt);
    end
  endtask

  task automatic test_random_traffic();
    set_coil(16'd1);
    random_cmds(230);
    set_coil(16'd3);
    random_cmds(230);
    // No idling on either side
    set_coil(16'd2);
    no_idle = 1'b1;
    random_cmds(230);
    no_idle = 1'b0;
    set_coil(16'd0);
    random_cmds(200);
    set_coil(16'hFFFF);
    random_cmds(60);
    set_coil(16'($urandom_range(1, 65535)));
    random_cmds(60);
    // Long hold-off on the result side so the input stalls
    set_coil(16'd4);
    hold_off_req = 1'b1;
    random_cmds(230);
    set_coil(16'($urandom_range(1, 6)));
    random_cmds(230);
  endtask

  // ---------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------
  initial begin
    rel_pos   = POS_UNKNOWN;
    seq_phase = PH_IDLE;
    tick_left = '0;
    hold_len  = '0;
    coil_len  = COIL_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_set_toggle();
    test_zero_coil();
    test_pulse();
    test_unmapped_register();
    test_max_coil();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
